@@ hdl/clock_sweep_page_replacement_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the clock sweep page replacement block
// Shared concurrent assertion forms, all clocked on clk; CSPR_ASSERT is gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SWEEP_PAGE_REPLACEMENT_MACROS_SVH
`define CLOCK_SWEEP_PAGE_REPLACEMENT_MACROS_SVH

// Property checked at every edge outside reset.
`define CSPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Property checked at every edge, reset included.
`define CSPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/cspr_pkg.sv @@
// ----------------------------------------------------------------------------
// cspr_pkg
// Types and codes shared by the clock page replacement controller and datapath.
// ----------------------------------------------------------------------------
package cspr_pkg;

  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_SWEEP  = 2'd2,
    ACT_RSVD   = 2'd3
  } action_t;

  localparam int unsigned FIDX_W = 3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] page;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame_index;
    logic              loaded;
    logic              evicted;
    logic [31:0]       evicted_page;
    logic              not_found;
    logic [31:0]       hit_count;
    logic [31:0]       miss_count;
    logic [31:0]       eviction_count;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the input transaction
    logic exec;     // perform the operation, load the result register
  } cmd_t;

endpackage

@@ hdl/cspr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cspr_ctrl
// Sequencer: capture, execute, and output register handshake.
// ----------------------------------------------------------------------------
module cspr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cspr_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign cmd.capture = in_valid && (state_r == S_IDLE);
  assign cmd.exec    = (state_r == S_EXEC) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (cmd.capture) state_nxt = S_EXEC;
      S_EXEC: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "clock_sweep_page_replacement_macros.svh"

  `CSPR_ASSERT(a_accept_to_exec, (in_valid && !in_stall) |=> (state_r == S_EXEC), "accepted transaction did not enter execute")
  `CSPR_ASSERT(a_no_overwrite, cmd.exec |-> !(out_valid_r && out_stall), "result register overwritten while held")
  `CSPR_ASSERT(a_result_from_exec, $rose(out_valid_r) |-> $past(state_r == S_EXEC), "result appeared without execute")

endmodule

@@ hdl/cspr_dp.sv @@
// ----------------------------------------------------------------------------
// cspr_dp
// Frame table, tag compare, clock hand victim search, counters, result register.
// ----------------------------------------------------------------------------
module cspr_dp #(
  parameter int unsigned NUM_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cspr_pkg::cmd_t cmd,
  input  cspr_pkg::in_t  in_data,
  output cspr_pkg::out_t out_data
);

  localparam int unsigned IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [IDX_W:0] NF = (IDX_W+1)'(NUM_FRAMES);

  // captured transaction
  logic [1:0]           act_r;
  logic [PAGE_BITS-1:0] pg_r;

  // frame table
  logic [PAGE_BITS-1:0] frame_page_r [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_valid_r, frame_valid_nxt;
  logic [NUM_FRAMES-1:0] frame_ref_r, frame_ref_nxt;
  logic [IDX_W-1:0]      hand_r, hand_nxt;
  logic [31:0]           hit_tot_r, hit_tot_nxt;
  logic [31:0]           miss_tot_r, miss_tot_nxt;
  logic [31:0]           evict_tot_r, evict_tot_nxt;
  cspr_pkg::out_t        out_r, out_nxt;

  // search results
  logic [NUM_FRAMES-1:0] match;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [NUM_FRAMES-1:0] cand;
  logic [NUM_FRAMES-1:0] rot_cand;
  logic                  found;
  logic [IDX_W-1:0]      k_sel;
  logic [IDX_W-1:0]      victim;
  logic [NUM_FRAMES-1:0] pass_mask;
  logic                  do_load;
  logic                  is_lookup_op;

  logic [IDX_W:0] pos;
  logic [IDX_W:0] gap;
  logic [IDX_W:0] vsum;
  logic [IDX_W:0] hsum;
  logic [63:0]    fidx_wide;

  // parallel tag compare, lowest index wins
  always_comb begin
    hit_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      match[i] = frame_valid_r[i] && (frame_page_r[i] == pg_r);
      if (match[i]) hit_idx = IDX_W'(i);
    end
    hit = |match;
  end

  // first empty or unreferenced frame at or after the hand
  always_comb begin
    k_sel = '0;
    found = 1'b0;
    cand  = ~frame_valid_r | ~frame_ref_r;
    for (int k = 0; k < NUM_FRAMES; k++) begin
      pos = {1'b0, hand_r} + (IDX_W+1)'(k);
      if (pos >= NF) pos = pos - NF;
      rot_cand[k] = cand[pos[IDX_W-1:0]];
    end
    for (int k = NUM_FRAMES - 1; k >= 0; k--) begin
      if (rot_cand[k]) begin
        k_sel = IDX_W'(k);
        found = 1'b1;
      end
    end
    vsum = {1'b0, hand_r} + {1'b0, k_sel};
    if (vsum >= NF) vsum = vsum - NF;
    victim = found ? vsum[IDX_W-1:0] : hand_r;
    // frames passed by the hand lose their reference bit; a full lap clears all
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (IDX_W'(i) >= hand_r) begin
        gap = (IDX_W+1)'(i) - {1'b0, hand_r};
      end else begin
        gap = (IDX_W+1)'(i) + NF - {1'b0, hand_r};
      end
      pass_mask[i] = !found || (gap < {1'b0, k_sel});
    end
    hsum = {1'b0, victim} + (IDX_W+1)'(1);
    if (hsum >= NF) hsum = '0;
  end

  assign is_lookup_op = (act_r == cspr_pkg::ACT_ACCESS) || (act_r == cspr_pkg::ACT_LOOKUP);
  assign do_load      = (act_r == cspr_pkg::ACT_ACCESS) && !hit;

  always_comb begin
    frame_valid_nxt = frame_valid_r;
    frame_ref_nxt   = frame_ref_r;
    hand_nxt        = hand_r;
    hit_tot_nxt     = hit_tot_r;
    miss_tot_nxt    = miss_tot_r;
    evict_tot_nxt   = evict_tot_r;
    fidx_wide       = '0;
    out_nxt         = '0;
    if (is_lookup_op) begin
      if (hit) begin
        frame_ref_nxt[hit_idx] = 1'b1;
        hit_tot_nxt = (hit_tot_r == '1) ? hit_tot_r : hit_tot_r + 32'd1;
        fidx_wide   = 64'(hit_idx);
        out_nxt.hit = 1'b1;
      end else if (act_r == cspr_pkg::ACT_LOOKUP) begin
        out_nxt.not_found = 1'b1;
      end else begin
        miss_tot_nxt = (miss_tot_r == '1) ? miss_tot_r : miss_tot_r + 32'd1;
        frame_ref_nxt = frame_ref_r & ~pass_mask;
        if (frame_valid_r[victim]) begin
          out_nxt.evicted      = 1'b1;
          out_nxt.evicted_page = 32'(frame_page_r[victim]);
          evict_tot_nxt = (evict_tot_r == '1) ? evict_tot_r : evict_tot_r + 32'd1;
        end
        frame_valid_nxt[victim] = 1'b1;
        frame_ref_nxt[victim]   = 1'b1;
        hand_nxt       = hsum[IDX_W-1:0];
        fidx_wide      = 64'(victim);
        out_nxt.loaded = 1'b1;
      end
    end else if (act_r == cspr_pkg::ACT_SWEEP) begin
      frame_ref_nxt = '0;
    end
    out_nxt.frame_index    = fidx_wide[cspr_pkg::FIDX_W-1:0];
    out_nxt.hit_count      = hit_tot_nxt;
    out_nxt.miss_count     = miss_tot_nxt;
    out_nxt.eviction_count = evict_tot_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_data.action;
      pg_r  <= PAGE_BITS'(in_data.page);
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
      if (do_load) frame_page_r[victim] <= pg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      frame_ref_r   <= '0;
      hand_r        <= '0;
      hit_tot_r     <= '0;
      miss_tot_r    <= '0;
      evict_tot_r   <= '0;
    end else if (cmd.exec) begin
      frame_valid_r <= frame_valid_nxt;
      frame_ref_r   <= frame_ref_nxt;
      hand_r        <= hand_nxt;
      hit_tot_r     <= hit_tot_nxt;
      miss_tot_r    <= miss_tot_nxt;
      evict_tot_r   <= evict_tot_nxt;
    end
  end

  assign out_data = out_r;

`include "clock_sweep_page_replacement_macros.svh"

  `CSPR_ASSERT(a_hand_range, {1'b0, hand_r} < NF, "clock hand out of range")
  `CSPR_ASSERT(a_unique_page, $countones(match) <= 1, "page resident in more than one frame")
  `CSPR_ASSERT(a_load_sets_bits, (cmd.exec && do_load) |=> (frame_valid_r[$past(victim)] && frame_ref_r[$past(victim)]), "loaded frame not valid and referenced")

endmodule

@@ hdl/clock_sweep_page_replacement.sv @@
// ----------------------------------------------------------------------------
// clock_sweep_page_replacement
// Fully associative frame pool with clock (second-chance) replacement.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  cspr_pkg::in_t  (action, page)
//   out_     output     out_valid/out_stall  cspr_pkg::out_t (flags, counts)
//
// Each transaction is captured in S_IDLE; S_EXEC then does the tag compare, the
// rotating victim search from the hand and the table update.
// One transaction in flight; the next is taken while a result waits.
// A stalled result holds in the output register; execute waits until it frees.
// Reset clears valid and reference bits, hand and counters.
// ----------------------------------------------------------------------------
module clock_sweep_page_replacement #(
  parameter int unsigned NUM_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cspr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cspr_pkg::out_t out_data
);

  cspr_pkg::cmd_t cmd;

  cspr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cspr_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ test/tb_clock_sweep_page_replacement.sv @@
// ----------------------------------------------------------------------------
// Testbench for clock_sweep_page_replacement
// Drives access, lookup, sweep and reserved transactions with random gaps
// and output stalls. A scoreboard predicts each result from its own copy of
// the frame table, reference bits, clock hand and saturating counters.
// ----------------------------------------------------------------------------

class frame_pool_scoreboard;
  localparam int FRAMES = 8;

  logic [31:0] frame_page [FRAMES];
  bit          frame_valid [FRAMES];
  bit          frame_ref [FRAMES];
  int          hand;
  bit [31:0]   hit_total;
  bit [31:0]   miss_total;
  bit [31:0]   evict_total;

  cspr_pkg::out_t expected_q[$];
  int errors;
  int n_hit, n_load, n_evict, n_not_found, n_sweep, n_rsvd;

  function new();
    for (int i = 0; i < FRAMES; i++) begin
      frame_page[i] = '0;
      frame_valid[i] = 1'b0;
      frame_ref[i] = 1'b0;
    end
    hand = 0;
    hit_total = '0;
    miss_total = '0;
    evict_total = '0;
    errors = 0;
  endfunction

  function bit [31:0] bump(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Work out the result of an accepted transaction and queue it.
  function void note_input(cspr_pkg::in_t item);
    cspr_pkg::out_t r;
    int slot;
    int pos;
    int steps;
    int i;
    r = '0;
    slot = -1;
    if (item.action == cspr_pkg::ACT_ACCESS || item.action == cspr_pkg::ACT_LOOKUP) begin
      for (i = 0; i < FRAMES; i++)
        if (slot < 0 && frame_valid[i] && frame_page[i] == item.page) slot = i;
      if (slot >= 0) begin
        frame_ref[slot] = 1'b1;
        hit_total = bump(hit_total);
        r.hit = 1'b1;
        r.frame_index = slot[2:0];
        n_hit++;
      end else if (item.action == cspr_pkg::ACT_LOOKUP) begin
        r.not_found = 1'b1;
        n_not_found++;
      end else begin
        miss_total = bump(miss_total);
        // second chance: clear referenced frames until an empty or cold one
        pos = hand;
        steps = 0;
        while (steps < 2 * FRAMES && frame_valid[pos] && frame_ref[pos]) begin
          frame_ref[pos] = 1'b0;
          pos = (pos + 1) % FRAMES;
          steps++;
        end
        hand = (pos + 1) % FRAMES;
        if (frame_valid[pos]) begin
          r.evicted = 1'b1;
          r.evicted_page = frame_page[pos];
          evict_total = bump(evict_total);
          n_evict++;
        end
        frame_page[pos] = item.page;
        frame_valid[pos] = 1'b1;
        frame_ref[pos] = 1'b1;
        r.loaded = 1'b1;
        r.frame_index = pos[2:0];
        n_load++;
      end
    end else if (item.action == cspr_pkg::ACT_SWEEP) begin
      for (i = 0; i < FRAMES; i++) frame_ref[i] = 1'b0;
      n_sweep++;
    end else begin
      n_rsvd++;
    end
    r.hit_count = hit_total;
    r.miss_count = miss_total;
    r.eviction_count = evict_total;
    expected_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_result(cspr_pkg::out_t got);
    cspr_pkg::out_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      return;
    end
    want = expected_q.pop_front();
    compare_field("hit", want.hit, got.hit);
    compare_field("frame_index", want.frame_index, got.frame_index);
    compare_field("loaded", want.loaded, got.loaded);
    compare_field("evicted", want.evicted, got.evicted);
    compare_field("evicted_page", want.evicted_page, got.evicted_page);
    compare_field("not_found", want.not_found, got.not_found);
    compare_field("hit_count", want.hit_count, got.hit_count);
    compare_field("miss_count", want.miss_count, got.miss_count);
    compare_field("eviction_count", want.eviction_count, got.eviction_count);
  endfunction
endclass

module tb_clock_sweep_page_replacement;
  localparam int RANDOM_ITEMS   = 630;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_SIZE      = 12;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  cspr_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  cspr_pkg::out_t out_data;

  frame_pool_scoreboard sb;
  bit calm;
  int quiet;

  clock_sweep_page_replacement u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Present one transaction, hold it until the block takes it.
  task automatic send_item(input cspr_pkg::action_t act, input logic [31:0] page);
    cspr_pkg::in_t item;
    item.action = act;
    item.page = page;
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
  endtask

  // Result side: random stalls, check every accepted result.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [31:0] page_pool [POOL_SIZE];
    logic [31:0] page;
    int k;
    int pick;
    cspr_pkg::action_t act;

    sb = new();
    calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pool, fill all frames, hits, eviction after a full lap,
    // sweep, second chance skipping a re-referenced frame, reserved action.
    send_item(cspr_pkg::ACT_LOOKUP, 32'h0000_0000);
    send_item(cspr_pkg::ACT_ACCESS, 32'h0000_0000);
    send_item(cspr_pkg::ACT_ACCESS, 32'hFFFF_FFFF);
    send_item(cspr_pkg::ACT_ACCESS, 32'h5555_5555);
    send_item(cspr_pkg::ACT_ACCESS, 32'hAAAA_AAAA);
    send_item(cspr_pkg::ACT_ACCESS, 32'h8000_0000);
    send_item(cspr_pkg::ACT_ACCESS, 32'h0000_0001);
    send_item(cspr_pkg::ACT_ACCESS, 32'h1234_5678);
    send_item(cspr_pkg::ACT_ACCESS, 32'h7FFF_FFFF);
    send_item(cspr_pkg::ACT_ACCESS, 32'hFFFF_FFFF);
    send_item(cspr_pkg::ACT_LOOKUP, 32'hAAAA_AAAA);
    send_item(cspr_pkg::ACT_LOOKUP, 32'hDEAD_BEEF);
    send_item(cspr_pkg::ACT_RSVD, 32'hFFFF_FFFF);
    send_item(cspr_pkg::ACT_ACCESS, 32'hCAFE_F00D);
    send_item(cspr_pkg::ACT_SWEEP, 32'hFFFF_FFFF);
    send_item(cspr_pkg::ACT_ACCESS, 32'h0BAD_F00D);
    send_item(cspr_pkg::ACT_ACCESS, 32'h5555_5555);
    send_item(cspr_pkg::ACT_ACCESS, 32'h1357_9BDF);
    send_item(cspr_pkg::ACT_ACCESS, 32'h0000_0000);
    send_item(cspr_pkg::ACT_LOOKUP, 32'h0000_0000);
    send_item(cspr_pkg::ACT_SWEEP, 32'h0000_0000);
    send_item(cspr_pkg::ACT_RSVD, 32'h0000_0000);

    // drain completely before the random phase
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    // Working set a bit larger than the pool: plenty of hits and evictions.
    for (k = 0; k < POOL_SIZE; k++) page_pool[k] = $urandom;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 250 && k < 400);
      if ($urandom_range(99) < 3) page_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
      if ($urandom_range(99) < 10) page = $urandom;
      else page = page_pool[$urandom_range(POOL_SIZE - 1)];
      pick = $urandom_range(99);
      if (pick < 60) act = cspr_pkg::ACT_ACCESS;
      else if (pick < 85) act = cspr_pkg::ACT_LOOKUP;
      else if (pick < 93) act = cspr_pkg::ACT_SWEEP;
      else act = cspr_pkg::ACT_RSVD;
      send_item(act, page);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end

    $display("Ran %0d directed and random transactions: %0d hits, %0d loads, %0d evictions,",
             22 + RANDOM_ITEMS, sb.n_hit, sb.n_load, sb.n_evict);
    $display("%0d lookup misses, %0d sweeps, %0d reserved ops; %0d mismatches",
             sb.n_not_found, sb.n_sweep, sb.n_rsvd, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/cspr_pkg.sv
hdl/cspr_ctrl.sv
hdl/cspr_dp.sv
hdl/clock_sweep_page_replacement.sv
test/tb_clock_sweep_page_replacement.sv
